>>> rtl/pfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg: shared definitions of the postfix expression evaluator
// Character codes, operation codes, the queue entry and ALU request types
// and the defaults of the top-level parameters.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned RESULT_W = 32;
  localparam int unsigned DIGIT_W  = 4;

  localparam logic [SYMBOL_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [SYMBOL_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [SYMBOL_W-1:0] CH_NINE   = 8'h39;
  localparam logic [SYMBOL_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [SYMBOL_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [SYMBOL_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [SYMBOL_W-1:0] CH_SLASH  = 8'h2F;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_DROP,
    OP_END
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [DIGIT_W-1:0] digit;
  } pfe_op_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } pfe_alu_req_t;

endpackage

>>> rtl/pfe_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_in_if: input channel of the postfix expression evaluator
// One expression character or an end marker per item.
// ----------------------------------------------------------------------------
interface pfe_in_if import pfe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                end_of_expression;

  modport source (output valid, symbol, end_of_expression, input ready);
  modport sink   (input valid, symbol, end_of_expression, output ready);
endinterface

>>> rtl/pfe_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_out_if: result channel of the postfix expression evaluator
// One final value with its sticky error flags per item.
// ----------------------------------------------------------------------------
interface pfe_out_if import pfe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] value;
  logic                       underflow;
  logic                       overflow;
  logic                       divide_by_zero;

  modport source (output valid, value, underflow, overflow, divide_by_zero, input ready);
  modport sink   (input valid, value, underflow, overflow, divide_by_zero, output ready);
endinterface

>>> rtl/pfe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module pfe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_front: input decoder and operation queue
// Classifies each character into an operation and holds up to two decoded
// items for the execution side.
// ----------------------------------------------------------------------------
module pfe_front import pfe_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  pfe_in_if.sink        in_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output pfe_op_t       q_op_o
);

  pfe_op_t    entry_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] count_q, count_d;
  pfe_op_t    dec;
  logic [SYMBOL_W-1:0] offset;
  logic       push, pop;

  always_comb begin
    offset    = in_i.symbol - CH_ZERO;
    dec.digit = offset[DIGIT_W-1:0];
    if (in_i.end_of_expression) begin
      dec.op = OP_END;
    end else if (in_i.symbol >= CH_ZERO && in_i.symbol <= CH_NINE) begin
      dec.op = OP_PUSH;
    end else begin
      case (in_i.symbol)
        CH_PLUS:  dec.op = OP_ADD;
        CH_MINUS: dec.op = OP_SUB;
        CH_STAR:  dec.op = OP_MUL;
        CH_SLASH: dec.op = OP_DIV;
        default:  dec.op = OP_DROP;
      endcase
    end
  end

  assign in_i.ready = (count_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (count_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_op_o     = entry_q[rd_q];

  always_comb begin
    wr_d    = push ? ~wr_q : wr_q;
    rd_d    = pop  ? ~rd_q : rd_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= dec;
    end
  end

endmodule

>>> rtl/pfe_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_alu: iterative multiply and signed divide unit
// Shift-and-add multiply and restoring divide on magnitudes, one bit per
// cycle, with a final state that fixes up the quotient sign.
// ----------------------------------------------------------------------------
module pfe_alu import pfe_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pfe_alu_req_t           req_i,
  input  logic [VALUE_WIDTH-1:0] a_i,
  input  logic [VALUE_WIDTH-1:0] b_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] result_o
);

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(VW);

  typedef enum logic [1:0] {
    AL_IDLE,
    AL_RUN,
    AL_FIX
  } alu_state_e;

  alu_state_e     state_q, state_d;
  logic [VW-1:0]  x_q, x_d;
  logic [VW-1:0]  y_q, y_d;
  logic [VW-1:0]  acc_q, acc_d;
  logic [VW-1:0]  rem_q, rem_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           div_q, div_d;
  logic           neg_q, neg_d;
  logic           done_q, done_d;
  logic [VW-1:0]  result_q, result_d;
  logic [VW:0]    trial;
  logic [VW:0]    diff;

  always_comb begin
    state_d  = state_q;
    x_d      = x_q;
    y_d      = y_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    div_d    = div_q;
    neg_d    = neg_q;
    done_d   = 1'b0;
    result_d = result_q;
    trial    = {rem_q, x_q[VW-1]};
    diff     = trial - {1'b0, y_q};

    case (state_q)
      AL_IDLE: begin
        if (req_i.start) begin
          div_d   = req_i.is_div;
          cnt_d   = '0;
          acc_d   = '0;
          rem_d   = '0;
          neg_d   = a_i[VW-1] ^ b_i[VW-1];
          state_d = AL_RUN;
          if (req_i.is_div) begin
            x_d = a_i[VW-1] ? (~a_i + 1'b1) : a_i;
            y_d = b_i[VW-1] ? (~b_i + 1'b1) : b_i;
          end else begin
            x_d = a_i;
            y_d = b_i;
          end
        end
      end
      AL_RUN: begin
        if (div_q) begin
          // The quotient bits shift into x as the dividend bits shift out.
          if (!diff[VW]) begin
            rem_d = diff[VW-1:0];
            x_d   = {x_q[VW-2:0], 1'b1};
          end else begin
            rem_d = trial[VW-1:0];
            x_d   = {x_q[VW-2:0], 1'b0};
          end
        end else begin
          if (y_q[0]) begin
            acc_d = acc_q + x_q;
          end
          x_d = {x_q[VW-2:0], 1'b0};
          y_d = {1'b0, y_q[VW-1:1]};
        end
        if (cnt_q == CW'(VW - 1)) begin
          state_d = AL_FIX;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      AL_FIX: begin
        if (div_q) begin
          result_d = neg_q ? (~x_q + 1'b1) : x_q;
        end else begin
          result_d = acc_q;
        end
        done_d  = 1'b1;
        state_d = AL_IDLE;
      end
      default: state_d = AL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= AL_IDLE;
      x_q      <= '0;
      y_q      <= '0;
      acc_q    <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      div_q    <= 1'b0;
      neg_q    <= 1'b0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      state_q  <= state_d;
      x_q      <= x_d;
      y_q      <= y_d;
      acc_q    <= acc_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      div_q    <= div_d;
      neg_q    <= neg_d;
      done_q   <= done_d;
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

>>> rtl/pfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_back: stack sequencer and result register
// Pops operands from the stack RAM, runs the operation, pushes the result
// and presents the final value of each expression.
// ----------------------------------------------------------------------------
module pfe_back import pfe_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  output logic     q_ready_o,
  input  pfe_op_t  q_op_i,
  pfe_out_if.source out_o
);

  localparam int unsigned VW    = VALUE_WIDTH;
  localparam int unsigned AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SPW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EXT_W = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_B,
    ST_WAIT_B,
    ST_POP_A,
    ST_WAIT_A,
    ST_EXEC,
    ST_ALU,
    ST_EMIT
  } back_state_e;

  back_state_e         state_q, state_d;
  op_e                 op_q, op_d;
  logic [SPW-1:0]      sp_q, sp_d;
  logic                under_q, under_d;
  logic                over_q, over_d;
  logic                dz_q, dz_d;
  logic [VW-1:0]       a_q, a_d;
  logic [VW-1:0]       b_q, b_d;
  logic                out_valid_q, out_valid_d;
  logic [RESULT_W-1:0] out_value_q, out_value_d;
  logic                out_uf_q, out_uf_d;
  logic                out_of_q, out_of_d;
  logic                out_dz_q, out_dz_d;

  logic                ram_we;
  logic [VW-1:0]       ram_wdata;
  logic [VW-1:0]       ram_rdata;
  logic [SPW-1:0]      sp_dec;
  logic                full, empty;
  logic                push_req;
  logic [VW-1:0]       push_val;
  pfe_alu_req_t        alu_req;
  logic                alu_done;
  logic [VW-1:0]       alu_result;
  logic [EXT_W-1:0]    ext;
  logic [VW-1:0]       empty_mark;

  assign full       = (sp_q == SPW'(STACK_DEPTH));
  assign empty      = (sp_q == '0);
  assign sp_dec     = sp_q - 1'b1;
  assign empty_mark = VW'(CH_DOLLAR);
  assign ext        = EXT_W'(signed'(b_q));

  pfe_ram #(
    .WIDTH (VW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sp_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (sp_dec[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  pfe_alu #(
    .VALUE_WIDTH (VW)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (a_q),
    .b_i      (b_q),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    sp_d        = sp_q;
    under_d     = under_q;
    over_d      = over_q;
    dz_d        = dz_q;
    a_d         = a_q;
    b_d         = b_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_uf_d    = out_uf_q;
    out_of_d    = out_of_q;
    out_dz_d    = out_dz_q;
    q_ready_o   = 1'b0;
    push_req    = 1'b0;
    push_val    = '0;
    alu_req     = '0;
    ram_we      = 1'b0;
    ram_wdata   = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_ready_o = 1'b1;
          op_d      = q_op_i.op;
          if (q_op_i.op == OP_PUSH) begin
            push_req = 1'b1;
            push_val = VW'(q_op_i.digit);
          end else begin
            state_d = ST_POP_B;
          end
        end
      end
      ST_POP_B: begin
        if (empty) begin
          under_d = 1'b1;
          b_d     = empty_mark;
          state_d = (op_q == OP_END) ? ST_EMIT : ST_POP_A;
        end else begin
          sp_d    = sp_dec;
          state_d = ST_WAIT_B;
        end
      end
      ST_WAIT_B: begin
        b_d     = ram_rdata;
        state_d = (op_q == OP_END) ? ST_EMIT : ST_POP_A;
      end
      ST_POP_A: begin
        if (empty) begin
          under_d = 1'b1;
          a_d     = empty_mark;
          state_d = ST_EXEC;
        end else begin
          sp_d    = sp_dec;
          state_d = ST_WAIT_A;
        end
      end
      ST_WAIT_A: begin
        a_d     = ram_rdata;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        case (op_q)
          OP_ADD: begin
            push_req = 1'b1;
            push_val = a_q + b_q;
          end
          OP_SUB: begin
            push_req = 1'b1;
            push_val = a_q - b_q;
          end
          OP_MUL: begin
            alu_req.start = 1'b1;
            state_d       = ST_ALU;
          end
          OP_DIV: begin
            if (b_q == '0) begin
              dz_d     = 1'b1;
              push_req = 1'b1;
            end else begin
              alu_req.start  = 1'b1;
              alu_req.is_div = 1'b1;
              state_d        = ST_ALU;
            end
          end
          default: ;
        endcase
      end
      ST_ALU: begin
        if (alu_done) begin
          push_req = 1'b1;
          push_val = alu_result;
          state_d  = ST_IDLE;
        end
      end
      ST_EMIT: begin
        // The flags already include an underflow of the final pop.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_value_d = ext[RESULT_W-1:0];
          out_uf_d    = under_q;
          out_of_d    = over_q;
          out_dz_d    = dz_q;
          sp_d        = '0;
          under_d     = 1'b0;
          over_d      = 1'b0;
          dz_d        = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (push_req) begin
      if (full) begin
        over_d = 1'b1;
      end else begin
        ram_we    = 1'b1;
        ram_wdata = push_val;
        sp_d      = sp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_PUSH;
      sp_q        <= '0;
      under_q     <= 1'b0;
      over_q      <= 1'b0;
      dz_q        <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_uf_q    <= 1'b0;
      out_of_q    <= 1'b0;
      out_dz_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      sp_q        <= sp_d;
      under_q     <= under_d;
      over_q      <= over_d;
      dz_q        <= dz_d;
      a_q         <= a_d;
      b_q         <= b_d;
      out_valid_q <= out_valid_d;
      out_value_q <= out_value_d;
      out_uf_q    <= out_uf_d;
      out_of_q    <= out_of_d;
      out_dz_q    <= out_dz_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.value          = signed'(out_value_q);
  assign out_o.underflow      = out_uf_q;
  assign out_o.overflow       = out_of_q;
  assign out_o.divide_by_zero = out_dz_q;

endmodule

>>> rtl/postfix_expression_evaluator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top: postfix expression evaluation stack
// Evaluates postfix expressions one character per item on an operand stack
// and reports the final value with sticky error flags.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                        Item
//  in_i     in   symbol[7:0], end_of_expression                 one character
//  out_o    out  value[31:0] signed, underflow, overflow,       one per end item
//                divide_by_zero
//
//  A digit is pushed straight from idle; add, subtract and other characters
//  pop each operand through a pop state and a wait state for the registered
//  stack RAM read, then execute. Multiply and divide then wait for the
//  one-bit-per-cycle multiply/divide unit; a zero divisor skips the unit.
//  An end item pops the top value and waits for a free result register.
//  Reset clears the stack pointer and flags at once; there is no clearing pass.
//  A two-item queue lets input continue while the sequencer or a waiting
//  result stalls; the result register holds until taken.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_top import pfe_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfe_in_if.sink    in_i,
  pfe_out_if.source out_o
);

  logic    q_valid;
  logic    q_ready;
  pfe_op_t q_op;

  pfe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_op_o    (q_op)
  );

  pfe_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_op_i    (q_op),
    .out_o     (out_o)
  );

endmodule

>>> rtl/pfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_checker: port-level checks of the postfix expression evaluator
// Tracks end items against results and checks that stalled results hold.
// ----------------------------------------------------------------------------
module pfe_checker import pfe_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                in_end_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [RESULT_W-1:0] out_value_i,
  input logic                out_uf_i,
  input logic                out_of_i,
  input logic                out_dz_i
);

  logic [3:0] pending_q;
  logic       end_acc;
  logic       out_acc;

  assign end_acc = in_valid_i && in_ready_i && in_end_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Number of end items taken whose results have not been delivered yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {3'b000, end_acc} - {3'b000, out_acc};
    end
  end

  a_no_result_without_end: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_valid_i |-> (pending_q != 4'd0))
    else $error("result item without a pending end item");

  a_pending_bounded: assert property (
    @(posedge clk_i) disable iff (!rst_ni) pending_q <= 4'd4)
    else $error("more end items pending than the design can hold");

  a_last_result_drops: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_acc && (pending_q == 4'd1) |=> !out_valid_i)
    else $error("result repeated after the last pending end item");

  a_result_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i)
      && $stable(out_uf_i) && $stable(out_of_i) && $stable(out_dz_i))
    else $error("stalled result item changed");

endmodule

bind postfix_expression_evaluator_top pfe_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_end_i    (in_i.end_of_expression),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.value),
  .out_uf_i    (out_o.underflow),
  .out_of_i    (out_o.overflow),
  .out_dz_i    (out_o.divide_by_zero)
);
